// File: hw/rtl/zlib_wrapper_framer_checker_defines.svh
// Assertion macros for the zlib wrapper framer/checker.
// Clock is clk_i, reset is rst_ni (active low) in every user of these macros.
`ifndef ZLIB_WRAPPER_FRAMER_CHECKER_DEFINES_SVH
`define ZLIB_WRAPPER_FRAMER_CHECKER_DEFINES_SVH
`ifndef SYNTH
`define ZWFC_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("zwfc assertion failed");
`define ZWFC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("zwfc assertion failed");
`else
`define ZWFC_ASSERT(lbl, ante, cons)
`define ZWFC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: hw/rtl/zwfc_pkg.sv
// ----------------------------------------------------------------------------
// zwfc_pkg
// Types, codes and helper functions shared by the zlib wrapper framer/checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package zwfc_pkg;

  typedef enum logic [2:0] {
    REQ_RAW     = 3'd0,
    REQ_COMP    = 3'd1,
    REQ_END     = 3'd2,
    REQ_FINISH  = 3'd3,
    REQ_RESTART = 3'd4
  } req_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_HDR  = 3'd1,
    ST_DICT     = 3'd2,
    ST_MISMATCH = 3'd3,
    ST_COMPLETE = 3'd4,
    ST_TRUNC    = 3'd5,
    ST_UNEXP    = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_BODY    = 2'd1,
    PH_TRAILER = 2'd2,
    PH_DONE    = 2'd3
  } phase_e;

  typedef enum logic {
    REG_ENCODE_MODE = 1'b0,
    REG_LEVEL       = 1'b1
  } reg_e;

  localparam logic [7:0]  CMF_BYTE   = 8'h78;
  localparam logic [3:0]  CM_DEFLATE = 4'd8;
  localparam logic [3:0]  CINFO_MAX  = 4'd7;
  localparam int unsigned FDICT_BIT  = 5;
  localparam logic [16:0] ADLER_MOD  = 17'd65521;
  localparam logic [3:0]  LEVEL_RST  = 4'd6;

  // One queued job: optional header pair, then either a trailer or a single word.
  typedef struct packed {
    logic        hdr;
    logic [7:0]  flg;
    logic        trl;
    logic        pvalid;
    logic [31:0] payload;
    status_e     status;
  } job_t;

  // FLG byte with FLEVEL from the level and FCHECK making CMF/FLG a multiple of 31.
  function automatic logic [7:0] flg_byte(input logic [3:0] level);
    logic [7:0] f;
    if (level <= 4'd1) begin
      f = 8'h01;
    end else if (level <= 4'd5) begin
      f = 8'h5E;
    end else if (level == 4'd6) begin
      f = 8'h9C;
    end else begin
      f = 8'hDA;
    end
    return f;
  endfunction

  // 32 == 1 (mod 31): fold 5-bit digits.
  function automatic logic mod31_zero(input logic [15:0] v);
    logic [6:0] s;
    logic [5:0] t;
    s = 7'(v[4:0]) + 7'(v[9:5]) + 7'(v[14:10]) + 7'(v[15]);
    t = 6'(s[4:0]) + 6'(s[6:5]);
    return (t == 6'd0) || (t == 6'd31);
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/zwfc_front.sv
// ----------------------------------------------------------------------------
// zwfc_front
// Accepts request words, tracks stream phase and Adler-32, and queues jobs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module zwfc_front (
  input  var logic              clk_i,
  input  var logic              rst_ni,
  input  var logic              encode_mode_i,
  input  var logic [3:0]        level_i,
  input  var logic              req_valid_i,
  output var logic              req_ready_o,
  input  var logic [2:0]        req_type_i,
  input  var logic [7:0]        data_byte_i,
  input  var logic              q_full_i,
  output var logic              push_o,
  output var zwfc_pkg::job_t    job_o
);

  zwfc_pkg::phase_e phase_q, phase_d;
  logic [1:0]  hcnt_q, hcnt_d;
  logic [15:0] stash_q, stash_d;
  logic [15:0] low_q, low_d;
  logic [15:0] high_q, high_d;
  logic [31:0] tshift_q, tshift_d;
  logic [2:0]  tcnt_q, tcnt_d;
  logic        err_q, err_d;

  logic        accept;
  logic [16:0] a_sum, b_sum;
  logic [15:0] a_new, b_new;
  logic        hdr_now;
  logic [7:0]  cmf;

  assign req_ready_o = ~q_full_i;
  assign accept      = req_valid_i & ~q_full_i;
  assign push_o      = accept;
  assign hdr_now     = (phase_q == zwfc_pkg::PH_HEADER);
  assign cmf         = stash_q[7:0];

  // Adler-32 update: add and conditional subtract on each sum
  always_comb begin
    a_sum = {1'b0, low_q} + 17'(data_byte_i);
    a_new = (a_sum >= zwfc_pkg::ADLER_MOD) ? 16'(a_sum - zwfc_pkg::ADLER_MOD) : a_sum[15:0];
    b_sum = {1'b0, high_q} + {1'b0, a_new};
    b_new = (b_sum >= zwfc_pkg::ADLER_MOD) ? 16'(b_sum - zwfc_pkg::ADLER_MOD) : b_sum[15:0];
  end

  always_comb begin
    phase_d  = phase_q;
    hcnt_d   = hcnt_q;
    stash_d  = stash_q;
    low_d    = low_q;
    high_d   = high_q;
    tshift_d = tshift_q;
    tcnt_d   = tcnt_q;
    err_d    = err_q;
    job_o         = '0;
    job_o.flg     = zwfc_pkg::flg_byte(level_i);
    job_o.status  = zwfc_pkg::ST_OK;

    priority if (req_type_i == zwfc_pkg::REQ_RESTART) begin
      phase_d  = zwfc_pkg::PH_HEADER;
      hcnt_d   = 2'd0;
      stash_d  = 16'd0;
      low_d    = 16'd1;
      high_d   = 16'd0;
      tshift_d = 32'd0;
      tcnt_d   = 3'd0;
      err_d    = 1'b0;
    end else if (req_type_i > zwfc_pkg::REQ_RESTART || err_q) begin
      job_o.status = zwfc_pkg::ST_UNEXP;
    end else if (encode_mode_i) begin
      if (phase_q == zwfc_pkg::PH_HEADER || phase_q == zwfc_pkg::PH_BODY) begin
        unique case (req_type_i)
          zwfc_pkg::REQ_RAW: begin
            low_d  = a_new;
            high_d = b_new;
          end
          zwfc_pkg::REQ_COMP: begin
            job_o.hdr     = hdr_now;
            job_o.pvalid  = 1'b1;
            job_o.payload = 32'(data_byte_i);
            phase_d       = zwfc_pkg::PH_BODY;
          end
          zwfc_pkg::REQ_END: begin
            job_o.hdr     = hdr_now;
            job_o.trl     = 1'b1;
            job_o.payload = {high_q, low_q};
            phase_d       = zwfc_pkg::PH_DONE;
          end
          default: begin
            err_d        = 1'b1;
            job_o.status = zwfc_pkg::ST_TRUNC;
          end
        endcase
      end else if (req_type_i == zwfc_pkg::REQ_FINISH) begin
        job_o.status = zwfc_pkg::ST_COMPLETE;
      end else begin
        job_o.status = zwfc_pkg::ST_UNEXP;
      end
    end else begin
      priority if (req_type_i == zwfc_pkg::REQ_FINISH) begin
        if (phase_q == zwfc_pkg::PH_DONE) begin
          job_o.status = zwfc_pkg::ST_COMPLETE;
        end else begin
          err_d        = 1'b1;
          job_o.status = zwfc_pkg::ST_TRUNC;
        end
      end else if (hdr_now && req_type_i == zwfc_pkg::REQ_COMP) begin
        stash_d = {stash_q[7:0], data_byte_i};
        hcnt_d  = hcnt_q + 2'd1;
        if (hcnt_d >= 2'd2) begin
          // second header byte: CM, CINFO, FCHECK, then FDICT
          if (cmf[3:0] != zwfc_pkg::CM_DEFLATE || cmf[7:4] > zwfc_pkg::CINFO_MAX ||
              !zwfc_pkg::mod31_zero(stash_d)) begin
            job_o.status = zwfc_pkg::ST_BAD_HDR;
            err_d        = 1'b1;
          end else if (data_byte_i[zwfc_pkg::FDICT_BIT]) begin
            job_o.status = zwfc_pkg::ST_DICT;
            err_d        = 1'b1;
          end else begin
            phase_d = zwfc_pkg::PH_BODY;
          end
        end
      end else if (phase_q == zwfc_pkg::PH_BODY && req_type_i == zwfc_pkg::REQ_COMP) begin
        job_o.pvalid  = 1'b1;
        job_o.payload = 32'(data_byte_i);
      end else if (phase_q == zwfc_pkg::PH_BODY && req_type_i == zwfc_pkg::REQ_RAW) begin
        low_d  = a_new;
        high_d = b_new;
      end else if (phase_q == zwfc_pkg::PH_BODY && req_type_i == zwfc_pkg::REQ_END) begin
        phase_d  = zwfc_pkg::PH_TRAILER;
        tcnt_d   = 3'd0;
        tshift_d = 32'd0;
      end else if (phase_q == zwfc_pkg::PH_TRAILER && req_type_i == zwfc_pkg::REQ_COMP) begin
        tshift_d = {tshift_q[23:0], data_byte_i};
        tcnt_d   = tcnt_q + 3'd1;
        if (tcnt_d >= 3'd4) begin
          if (tshift_d == {high_q, low_q}) begin
            phase_d      = zwfc_pkg::PH_DONE;
            job_o.status = zwfc_pkg::ST_COMPLETE;
          end else begin
            err_d        = 1'b1;
            job_o.status = zwfc_pkg::ST_MISMATCH;
          end
        end
      end else begin
        job_o.status = zwfc_pkg::ST_UNEXP;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= zwfc_pkg::PH_HEADER;
      hcnt_q   <= 2'd0;
      stash_q  <= 16'd0;
      low_q    <= 16'd1;
      high_q   <= 16'd0;
      tshift_q <= 32'd0;
      tcnt_q   <= 3'd0;
      err_q    <= 1'b0;
    end else if (accept) begin
      phase_q  <= phase_d;
      hcnt_q   <= hcnt_d;
      stash_q  <= stash_d;
      low_q    <= low_d;
      high_q   <= high_d;
      tshift_q <= tshift_d;
      tcnt_q   <= tcnt_d;
      err_q    <= err_d;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/zwfc_queue.sv
// ----------------------------------------------------------------------------
// zwfc_queue
// Small job FIFO between the front and back halves.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module zwfc_queue #(
  parameter int unsigned Depth = 4
) (
  input  var logic           clk_i,
  input  var logic           rst_ni,
  input  var logic           push_i,
  input  var zwfc_pkg::job_t push_job_i,
  output var logic           full_o,
  input  var logic           pop_i,
  output var logic           head_valid_o,
  output var zwfc_pkg::job_t head_job_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  zwfc_pkg::job_t  slots_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_pop;

  assign full_o       = (cnt_q == CntFull);
  assign head_valid_o = (cnt_q != '0);
  assign head_job_o   = slots_q[rd_q];
  assign do_pop       = pop_i & head_valid_o;

  always_comb begin
    wr_d  = push_i ? ((wr_q == PtrLast) ? '0 : wr_q + PtrW'(1)) : wr_q;
    rd_d  = do_pop ? ((rd_q == PtrLast) ? '0 : rd_q + PtrW'(1)) : rd_q;
    cnt_d = cnt_q + CntW'(push_i) - CntW'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/zwfc_back.sv
// ----------------------------------------------------------------------------
// zwfc_back
// Expands queued jobs into result words, one per cycle while results are taken, into an output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module zwfc_back (
  input  var logic           clk_i,
  input  var logic           rst_ni,
  input  var logic           head_valid_i,
  input  var zwfc_pkg::job_t head_job_i,
  output var logic           pop_o,
  output var logic           res_valid_o,
  input  var logic           res_ready_i,
  output var logic           out_valid_o,
  output var logic [7:0]     out_byte_o,
  output var logic [2:0]     status_o,
  output var logic           last_o
);

  logic [2:0]        idx_q, idx_d;
  logic              rv_q;
  logic              ov_q, ov_d;
  logic [7:0]        ob_q, ob_d;
  zwfc_pkg::status_e st_q, st_d;
  logic              last_q, last_d;
  logic              load;
  logic [2:0]        last_idx, j;

  assign load = head_valid_i & (~rv_q | res_ready_i);

  always_comb begin
    last_idx = (head_job_i.hdr ? 3'd2 : 3'd0) + (head_job_i.trl ? 3'd3 : 3'd0);
    j        = idx_q - (head_job_i.hdr ? 3'd2 : 3'd0);
    last_d   = (idx_q == last_idx);
    ov_d     = 1'b1;
    st_d     = zwfc_pkg::ST_OK;
    if (head_job_i.hdr && idx_q < 3'd2) begin
      ob_d = (idx_q == 3'd0) ? zwfc_pkg::CMF_BYTE : head_job_i.flg;
    end else if (head_job_i.trl) begin
      // Adler-32 goes out big-endian
      unique case (j[1:0])
        2'd0:    ob_d = head_job_i.payload[31:24];
        2'd1:    ob_d = head_job_i.payload[23:16];
        2'd2:    ob_d = head_job_i.payload[15:8];
        default: ob_d = head_job_i.payload[7:0];
      endcase
      if (j[1:0] == 2'd3) begin
        st_d = zwfc_pkg::ST_COMPLETE;
      end
    end else begin
      ov_d = head_job_i.pvalid;
      ob_d = head_job_i.payload[7:0];
      st_d = head_job_i.status;
    end
    idx_d = last_d ? 3'd0 : idx_q + 3'd1;
  end

  assign pop_o = load & last_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv_q  <= 1'b0;
      idx_q <= 3'd0;
    end else begin
      if (load) begin
        rv_q  <= 1'b1;
        idx_q <= idx_d;
      end else if (res_ready_i) begin
        rv_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      ov_q   <= ov_d;
      ob_q   <= ob_d;
      st_q   <= st_d;
      last_q <= last_d;
    end
  end

  assign res_valid_o = rv_q;
  assign out_valid_o = ov_q;
  assign out_byte_o  = ob_q;
  assign status_o    = st_q;
  assign last_o      = last_q;

endmodule
`default_nettype wire

// File: hw/rtl/zlib_wrapper_framer_checker.sv
// Path: accepted request words go into the job queue; the back end loads result words from
// the queue head into the output register. Throughput: one request word per cycle while the
// job queue is not full; the back end emits one result word per cycle while results are
// taken, so header-plus-byte (3) and trailer (up to 6) jobs drain through the job queue.
// Reset: asynchronous, active low; encode_mode=0, compress_level=6, stream in header phase.
// ----------------------------------------------------------------------------
// zlib_wrapper_framer_checker
// RFC 1950 header/trailer framer and checker with running Adler-32.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "zlib_wrapper_framer_checker_defines.svh"
module zlib_wrapper_framer_checker #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  var logic        clk_i,
  input  var logic        rst_ni,
  input  var logic        psel,
  input  var logic        penable,
  input  var logic        pwrite,
  input  var logic [2:0]  paddr,
  input  var logic [31:0] pwdata,
  output var logic [31:0] prdata,
  output var logic        pready,
  input  var logic        req_valid_i,
  output var logic        req_ready_o,
  input  var logic [2:0]  req_type_i,
  input  var logic [7:0]  data_byte_i,
  output var logic        res_valid_o,
  input  var logic        res_ready_i,
  output var logic        out_valid_o,
  output var logic [7:0]  out_byte_o,
  output var logic [2:0]  status_o,
  output var logic        last_o
);

  logic           encode_mode_q;
  logic [3:0]     level_q;
  logic           cfg_wr;
  zwfc_pkg::reg_e cfg_sel;

  logic           push, full, pop, head_valid;
  zwfc_pkg::job_t push_job, head_job;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_sel = zwfc_pkg::reg_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      encode_mode_q <= 1'b0;
      level_q       <= zwfc_pkg::LEVEL_RST;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        zwfc_pkg::REG_ENCODE_MODE: encode_mode_q <= pwdata[0];
        default:                   level_q       <= pwdata[3:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      zwfc_pkg::REG_ENCODE_MODE: prdata = 32'(encode_mode_q);
      default:                   prdata = 32'(level_q);
    endcase
  end

  zwfc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .encode_mode_i (encode_mode_q),
    .level_i       (level_q),
    .req_valid_i   (req_valid_i),
    .req_ready_o   (req_ready_o),
    .req_type_i    (req_type_i),
    .data_byte_i   (data_byte_i),
    .q_full_i      (full),
    .push_o        (push),
    .job_o         (push_job)
  );

  zwfc_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_job_i   (push_job),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_job_o   (head_job)
  );

  zwfc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_job_i   (head_job),
    .pop_o        (pop),
    .res_valid_o  (res_valid_o),
    .res_ready_i  (res_ready_i),
    .out_valid_o  (out_valid_o),
    .out_byte_o   (out_byte_o),
    .status_o     (status_o),
    .last_o       (last_o)
  );

  // words without a byte carry zero
  `ZWFC_ASSERT(a_no_byte_zero, res_valid_o && !out_valid_o, out_byte_o == 8'd0)
  // only the closing word of a job may carry a non-ok status
  `ZWFC_ASSERT(a_mid_ok, res_valid_o && !last_o, status_o == zwfc_pkg::ST_OK)
  // a mode write lands in the register
  `ZWFC_ASSERT_NEXT(a_mode_wr, cfg_wr && !paddr[2], encode_mode_q == $past(pwdata[0]))

endmodule
`default_nettype wire

// File: tb/zlib_frame_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zlib frame monitor
// Watches the config port and both word channels of the zlib wrapper block.
// Keeps its own copy of the stream state and the registers, works out the
// result words that each accepted request word causes, and compares every
// accepted result word with the oldest expected one.
// ----------------------------------------------------------------------------
module zlib_frame_monitor
  import zwfc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic        req_valid_i,
  input  logic        req_ready_o,
  input  logic [2:0]  req_type_i,
  input  logic [7:0]  data_byte_i,
  input  logic        res_valid_o,
  input  logic        res_ready_i,
  input  logic        out_valid_o,
  input  logic [7:0]  out_byte_o,
  input  logic [2:0]  status_o,
  input  logic        last_o,
  output int          pending_o,
  output int          fails_o
);

  localparam int FCHECK_DIV = 31;
  localparam int MAX_WORDS  = 6;

  typedef struct packed {
    logic       ov;
    logic [7:0] ob;
    status_e    st;
    logic       lst;
  } zword_t;

  zword_t words_due[$];
  zword_t batch[MAX_WORDS];
  int     batch_n;
  zword_t head;

  // Register copies
  logic       enc_mode;
  logic [3:0] level;

  // Stream state
  phase_e      phase_q;
  logic [1:0]  hdr_cnt;
  logic [15:0] hdr_stash;
  logic [15:0] sum_lo;
  logic [15:0] sum_hi;
  logic [31:0] trl_shift;
  logic [2:0]  trl_cnt;
  logic        err_latched;

  function automatic void clear_stream();
    phase_q     = PH_HEADER;
    hdr_cnt     = 2'd0;
    hdr_stash   = 16'd0;
    sum_lo      = 16'd1;
    sum_hi      = 16'd0;
    trl_shift   = 32'd0;
    trl_cnt     = 3'd0;
    err_latched = 1'b0;
  endfunction

  function automatic void emit(input logic ov, input logic [7:0] ob, input status_e st);
    batch[batch_n] = '{ov, ov ? ob : 8'd0, st, 1'b0};
    batch_n++;
  endfunction

  function automatic void fold_adler(input logic [7:0] data);
    logic [16:0] a;
    logic [16:0] b;
    a = 17'(sum_lo) + 17'(data);
    if (a >= ADLER_MOD) a = a - ADLER_MOD;
    b = 17'(sum_hi) + a;
    if (b >= ADLER_MOD) b = b - ADLER_MOD;
    sum_lo = a[15:0];
    sum_hi = b[15:0];
  endfunction

  // FLEVEL from the level, FCHECK pads the CMF/FLG pair to a multiple of 31
  function automatic logic [7:0] level_flg(input logic [3:0] lvl);
    logic [1:0]  flevel;
    logic [15:0] pair;
    int          rem;
    flevel = (lvl <= 4'd1) ? 2'd0 : (lvl <= 4'd5) ? 2'd1 : (lvl == 4'd6) ? 2'd2 : 2'd3;
    pair   = {CMF_BYTE, flevel, 6'd0};
    rem    = int'(pair) % FCHECK_DIV;
    return {flevel, 6'd0} + ((rem == 0) ? 8'd0 : 8'(FCHECK_DIV - rem));
  endfunction

  function automatic void emit_header();
    emit(1'b1, CMF_BYTE, ST_OK);
    emit(1'b1, level_flg(level), ST_OK);
  endfunction

  function automatic void encode_step(input logic [2:0] kind, input logic [7:0] data);
    if (phase_q == PH_HEADER || phase_q == PH_BODY) begin
      if (kind == REQ_RAW) begin
        fold_adler(data);
        emit(1'b0, 8'd0, ST_OK);
      end else if (kind == REQ_COMP) begin
        if (phase_q == PH_HEADER) emit_header();
        phase_q = PH_BODY;
        emit(1'b1, data, ST_OK);
      end else if (kind == REQ_END) begin
        if (phase_q == PH_HEADER) emit_header();
        emit(1'b1, sum_hi[15:8], ST_OK);
        emit(1'b1, sum_hi[7:0], ST_OK);
        emit(1'b1, sum_lo[15:8], ST_OK);
        emit(1'b1, sum_lo[7:0], ST_COMPLETE);
        phase_q = PH_DONE;
      end else begin
        // finish before the trailer went out
        err_latched = 1'b1;
        emit(1'b0, 8'd0, ST_TRUNC);
      end
    end else if (kind == REQ_FINISH) begin
      emit(1'b0, 8'd0, ST_COMPLETE);
    end else begin
      emit(1'b0, 8'd0, ST_UNEXP);
    end
  endfunction

  function automatic void decode_step(input logic [2:0] kind, input logic [7:0] data);
    status_e st;
    if (kind == REQ_FINISH) begin
      if (phase_q == PH_DONE) begin
        emit(1'b0, 8'd0, ST_COMPLETE);
      end else begin
        err_latched = 1'b1;
        emit(1'b0, 8'd0, ST_TRUNC);
      end
    end else if (phase_q == PH_HEADER && kind == REQ_COMP) begin
      hdr_stash = {hdr_stash[7:0], data};
      hdr_cnt   = hdr_cnt + 2'd1;
      if (hdr_cnt < 2'd2) begin
        emit(1'b0, 8'd0, ST_OK);
      end else begin
        st = ST_OK;
        if (hdr_stash[11:8] != CM_DEFLATE || hdr_stash[15:12] > CINFO_MAX ||
            (int'(hdr_stash) % FCHECK_DIV) != 0) begin
          st = ST_BAD_HDR;
        end else if (hdr_stash[FDICT_BIT]) begin
          st = ST_DICT;
        end
        if (st != ST_OK) err_latched = 1'b1;
        else phase_q = PH_BODY;
        emit(1'b0, 8'd0, st);
      end
    end else if (phase_q == PH_BODY && kind == REQ_COMP) begin
      emit(1'b1, data, ST_OK);
    end else if (phase_q == PH_BODY && kind == REQ_RAW) begin
      fold_adler(data);
      emit(1'b0, 8'd0, ST_OK);
    end else if (phase_q == PH_BODY && kind == REQ_END) begin
      phase_q   = PH_TRAILER;
      trl_cnt   = 3'd0;
      trl_shift = 32'd0;
      emit(1'b0, 8'd0, ST_OK);
    end else if (phase_q == PH_TRAILER && kind == REQ_COMP) begin
      trl_shift = {trl_shift[23:0], data};
      trl_cnt   = trl_cnt + 3'd1;
      if (trl_cnt < 3'd4) begin
        emit(1'b0, 8'd0, ST_OK);
      end else if (trl_shift == {sum_hi, sum_lo}) begin
        phase_q = PH_DONE;
        emit(1'b0, 8'd0, ST_COMPLETE);
      end else begin
        err_latched = 1'b1;
        emit(1'b0, 8'd0, ST_MISMATCH);
      end
    end else begin
      emit(1'b0, 8'd0, ST_UNEXP);
    end
  endfunction

  function automatic void predict_framing(input logic [2:0] kind, input logic [7:0] data);
    batch_n = 0;
    if (kind == REQ_RESTART) begin
      clear_stream();
      emit(1'b0, 8'd0, ST_OK);
    end else if (kind > REQ_RESTART || err_latched) begin
      emit(1'b0, 8'd0, ST_UNEXP);
    end else if (enc_mode) begin
      encode_step(kind, data);
    end else begin
      decode_step(kind, data);
    end
    batch[batch_n-1].lst = 1'b1;
    for (int i = 0; i < batch_n; i++) words_due.push_back(batch[i]);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enc_mode = 1'b0;
      level    = LEVEL_RST;
      clear_stream();
      words_due.delete();
      pending_o = 0;
      fails_o   = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (reg_e'(paddr[2]) == REG_ENCODE_MODE) enc_mode = pwdata[0];
        else level = pwdata[3:0];
      end
      if (req_valid_i && req_ready_o) predict_framing(req_type_i, data_byte_i);
      if (res_valid_o && res_ready_i) begin
        if (words_due.size() == 0) begin
          if (fails_o < 10)
            $display("%0t: result word with nothing expected: valid=%0b byte=%02h status=%0d last=%0b",
                     $realtime, out_valid_o, out_byte_o, status_o, last_o);
          fails_o++;
        end else begin
          head = words_due.pop_front();
          if (out_valid_o !== head.ov || out_byte_o !== head.ob ||
              status_o !== head.st || last_o !== head.lst) begin
            if (fails_o < 10)
              $display("%0t: mismatch: expected valid=%0b byte=%02h status=%0d last=%0b, got valid=%0b byte=%02h status=%0d last=%0b",
                       $realtime, head.ov, head.ob, head.st, head.lst,
                       out_valid_o, out_byte_o, status_o, last_o);
            fails_o++;
          end
        end
      end
      pending_o = words_due.size();
    end
  end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zlib wrapper testbench
// Drives request words and the config port of the zlib wrapper block:
// directed header, trailer and error cases, then random streams in both
// modes, mostly well formed with some flaws and noise. Checking is done by
// the frame monitor beside the block.
// ----------------------------------------------------------------------------
module testbench;
  import zwfc_pkg::*;

  localparam int CYCLE_LIMIT    = 600000;
  localparam int RANDOM_WORDS   = 115;
  localparam int FCHECK_DIV     = 31;
  localparam int REQ_KINDS      = 5;
  localparam int REQ_CODE_MAX   = 7;
  localparam int LEVEL_MAX      = 9;

  typedef enum int {
    FLAW_NONE,
    FLAW_BAD_HDR,
    FLAW_DICT,
    FLAW_BAD_SUM,
    FLAW_CUT,
    FLAW_STRAY
  } flaw_e;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [2:0]  paddr       = 3'd0;
  logic [31:0] pwdata      = 32'd0;
  logic [31:0] prdata;
  logic        pready;
  logic        req_valid_i = 1'b0;
  logic        req_ready_o;
  logic [2:0]  req_type_i  = 3'd0;
  logic [7:0]  data_byte_i = 8'd0;
  logic        res_valid_o;
  logic        res_ready_i = 1'b0;
  logic        out_valid_o;
  logic [7:0]  out_byte_o;
  logic [2:0]  status_o;
  logic        last_o;

  int pending;
  int fails;
  int cycle_cnt  = 0;
  int words_sent = 0;
  int rdy_hold   = 0;
  bit calm       = 1'b0;

  // running Adler sums of the raw bytes sent, to build good trailers
  logic [15:0] run_lo = 16'd1;
  logic [15:0] run_hi = 16'd0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  zlib_wrapper_framer_checker dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .req_valid_i(req_valid_i),
    .req_ready_o(req_ready_o),
    .req_type_i (req_type_i),
    .data_byte_i(data_byte_i),
    .res_valid_o(res_valid_o),
    .res_ready_i(res_ready_i),
    .out_valid_o(out_valid_o),
    .out_byte_o (out_byte_o),
    .status_o   (status_o),
    .last_o     (last_o)
  );

  zlib_frame_monitor frame_mon (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .req_valid_i(req_valid_i),
    .req_ready_o(req_ready_o),
    .req_type_i (req_type_i),
    .data_byte_i(data_byte_i),
    .res_valid_o(res_valid_o),
    .res_ready_i(res_ready_i),
    .out_valid_o(out_valid_o),
    .out_byte_o (out_byte_o),
    .status_o   (status_o),
    .last_o     (last_o),
    .pending_o  (pending),
    .fails_o    (fails)
  );

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // mostly short idle stretches, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 50);
  endfunction

  always @(negedge clk_i) begin
    if (calm || rdy_hold == 0) begin
      res_ready_i <= 1'b1;
      if (!calm && $urandom_range(0, 4) == 0) rdy_hold = idle_len();
    end else begin
      res_ready_i <= 1'b0;
      rdy_hold--;
    end
  end

  // valid stays up after acceptance; a gap before the next word or a drain lowers it
  task automatic send_word(input logic [2:0] kind, input logic [7:0] data);
    int gap;
    gap = (calm || $urandom_range(0, 99) < 55) ? 0 : idle_len();
    @(negedge clk_i);
    if (gap > 0) begin
      req_valid_i <= 1'b0;
      req_type_i  <= 3'($urandom);
      data_byte_i <= 8'($urandom);
      repeat (gap) @(negedge clk_i);
    end
    req_valid_i <= 1'b1;
    req_type_i  <= kind;
    data_byte_i <= data;
    @(posedge clk_i);
    while (!req_ready_o) @(posedge clk_i);
    words_sent++;
  endtask

  task automatic wait_quiet();
    @(negedge clk_i);
    req_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic reg_write(input reg_e idx, input logic [3:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= 32'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_config(input logic mode, input logic [3:0] lvl);
    wait_quiet();
    reg_write(REG_ENCODE_MODE, 4'(mode));
    reg_write(REG_LEVEL, lvl);
  endtask

  task automatic start_stream();
    send_word(REQ_RESTART, 8'($urandom));
    run_lo = 16'd1;
    run_hi = 16'd0;
  endtask

  task automatic feed_raw(input logic [7:0] data);
    logic [16:0] a;
    logic [16:0] b;
    a = 17'(run_lo) + 17'(data);
    if (a >= ADLER_MOD) a = a - ADLER_MOD;
    b = 17'(run_hi) + a;
    if (b >= ADLER_MOD) b = b - ADLER_MOD;
    run_lo = a[15:0];
    run_hi = b[15:0];
    send_word(REQ_RAW, data);
  endtask

  task automatic send_trailer(input logic [31:0] sum);
    for (int k = 3; k >= 0; k--) send_word(REQ_COMP, sum[8*k +: 8]);
  endtask

  // body words, with an early finish or a stray code where the flaw asks
  task automatic send_body(input flaw_e flaw, output bit cut);
    int n;
    int cut_at;
    int stray_at;
    n        = $urandom_range(0, 10);
    cut_at   = $urandom_range(0, n);
    stray_at = $urandom_range(0, n);
    cut      = 1'b0;
    for (int i = 0; i <= n; i++) begin
      if (flaw == FLAW_CUT && i == cut_at) begin
        send_word(REQ_FINISH, 8'($urandom));
        cut = 1'b1;
        return;
      end
      if (flaw == FLAW_STRAY && i == stray_at)
        send_word(3'($urandom_range(REQ_KINDS, REQ_CODE_MAX)), 8'($urandom));
      if (i < n) begin
        if ($urandom_range(0, 1)) feed_raw(8'($urandom));
        else send_word(REQ_COMP, 8'($urandom));
      end
    end
  endtask

  task automatic encode_stream(input flaw_e flaw);
    bit cut;
    start_stream();
    send_body(flaw, cut);
    if (!cut) begin
      send_word(REQ_END, 8'($urandom));
      send_word(REQ_FINISH, 8'($urandom));
    end
  endtask

  task automatic decode_stream(input flaw_e flaw);
    logic [7:0]  cmf;
    logic [7:0]  flg;
    logic [15:0] pair;
    logic [31:0] sum;
    int          rem;
    bit          cut;
    start_stream();
    cmf  = {4'($urandom_range(0, CINFO_MAX)), CM_DEFLATE};
    flg  = {2'($urandom), (flaw == FLAW_DICT), 5'd0};
    pair = {cmf, flg};
    rem  = int'(pair) % FCHECK_DIV;
    if (rem != 0) flg = flg + 8'(FCHECK_DIV - rem);
    if (flaw == FLAW_BAD_HDR) begin
      case ($urandom_range(0, 3))
        0: cmf[3:0] = CM_DEFLATE ^ 4'($urandom_range(1, 15));
        1: cmf[7:4] = 4'($urandom_range(CINFO_MAX + 1, 15));
        2: flg[4:0] = flg[4:0] ^ 5'($urandom_range(1, 30));
        default: begin
          cmf = 8'($urandom);
          flg = 8'($urandom);
        end
      endcase
    end
    send_word(REQ_COMP, cmf);
    send_word(REQ_COMP, flg);
    send_body(flaw, cut);
    if (cut) return;
    send_word(REQ_END, 8'($urandom));
    sum = {run_hi, run_lo};
    if (flaw == FLAW_BAD_SUM) sum[$urandom_range(0, 31)] ^= 1'b1;
    send_trailer(sum);
    send_word(REQ_FINISH, 8'($urandom));
  endtask

  task automatic noise_burst();
    int          n;
    logic [2:0]  kind;
    n = $urandom_range(1, 6);
    for (int i = 0; i < n; i++) begin
      kind = 3'($urandom_range(0, REQ_CODE_MAX));
      if (kind == REQ_RAW) feed_raw(8'($urandom));
      else send_word(kind, 8'($urandom));
    end
  endtask

  initial begin
    int          base;
    int          r;
    logic [3:0]  lvl;
    flaw_e       flaw;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // decode at reset settings: good stream, then repeated finish and a bad code
    send_word(REQ_COMP, CMF_BYTE);
    send_word(REQ_COMP, 8'h9C);
    feed_raw(8'h00);
    feed_raw(8'hFF);
    send_word(REQ_COMP, 8'hAB);
    send_word(REQ_END, 8'h00);
    send_trailer({run_hi, run_lo});
    send_word(REQ_FINISH, 8'h00);
    send_word(REQ_FINISH, 8'hFF);
    send_word(3'(REQ_CODE_MAX), 8'h00);
    // bad CM, then the error latch swallows the next word
    start_stream();
    send_word(REQ_COMP, 8'h79);
    send_word(REQ_COMP, 8'h00);
    feed_raw(8'h55);
    // preset dictionary flagged
    start_stream();
    send_word(REQ_COMP, CMF_BYTE);
    send_word(REQ_COMP, 8'h20);

    // encode at the top level: header with the first compressed byte
    set_config(1'b1, 4'(LEVEL_MAX));
    start_stream();
    feed_raw(8'hFF);
    send_word(REQ_COMP, 8'h00);
    send_word(REQ_END, 8'h00);
    send_word(REQ_FINISH, 8'h00);
    // body end with no header yet: header and trailer in one go
    start_stream();
    send_word(REQ_END, 8'h00);
    // finish before anything went out
    start_stream();
    send_word(REQ_FINISH, 8'h00);

    set_config(1'b1, 4'd0);
    base = words_sent;
    while (words_sent - base < RANDOM_WORDS) begin
      calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 2) == 0) begin
        r   = $urandom_range(0, 9);
        lvl = (r == 0) ? 4'd0 : (r == 1) ? 4'(LEVEL_MAX) : 4'($urandom_range(0, LEVEL_MAX));
        set_config(1'($urandom), lvl);
      end
      r    = $urandom_range(0, 99);
      flaw = ($urandom_range(0, 99) < 60) ? FLAW_NONE
                                          : flaw_e'($urandom_range(FLAW_BAD_HDR, FLAW_STRAY));
      if (r < 80) begin
        if ($urandom_range(0, 1)) encode_stream(flaw);
        else decode_stream(flaw);
      end else begin
        noise_burst();
      end
    end
    calm = 1'b0;

    wait_quiet();
    repeat (8) @(posedge clk_i);
    if (fails == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: zlib_wrapper_framer_checker.f
+incdir+hw/rtl
hw/rtl/zwfc_pkg.sv
hw/rtl/zwfc_front.sv
hw/rtl/zwfc_queue.sv
hw/rtl/zwfc_back.sv
hw/rtl/zlib_wrapper_framer_checker.sv
tb/zlib_frame_monitor.sv
tb/testbench.sv
